// File: design/spa_pkg.sv
package spa_pkg;

  // round(2^32 / (2*pi)), radians to turns in Q0.32
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  // 2*pi and pi/2 in Q.30
  localparam logic [32:0] TWO_PI_Q30     = 33'd6746518852;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  // round(a / 24 * 2^32), quartic coefficient
  localparam logic [27:0] QUARTIC_Q32    = 28'd168796000;
  localparam logic [30:0] ONE_Q30        = 31'd1073741824;

  // register stages from an accepted item to its result strobe
  localparam int unsigned PIPE_DEPTH = 8;

  typedef struct packed {
    logic vld;
    logic neg;
  } spa_ctl_t;

endpackage

// File: design/sine_poly_approx.sv
// quartic polynomial sine, fully pipelined
//
// input: pulse start with in_kind (0 turns, 1 radians) and in_angle, a signed
// Q16.16 angle. busy is never raised, so an item is taken on every cycle that
// start is high, back to back at one item per cycle.
// output: out_valid strobes for one cycle with out_sine, the sine in signed
// Q1.OUT_FRAC_BITS within [-1, +1], its magnitude rounded half up.
// the eight register stages from the accepting edge to the result strobe are
// radian scaling, phase multiply, phase offset and abs, t^2, t^4, quartic
// term, sum and clamp, round and sign.
// each stage holds at most one multiply, with operands of at most 33 bits.
// results appear in input order and cannot be held off; the receiver must
// take each one in its strobe cycle.
// reset (synchronous, active low) clears all valid bits, dropping items in
// flight; no result strobes until new items arrive. there is no state
// beyond the pipeline, so no clearing pass is needed.
module sine_poly_approx
  import spa_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic signed [31:0]        in_angle,
  output logic                      out_valid,
  output logic signed [OUT_FRAC_BITS+1:0] out_sine
);

  localparam int SW    = OUT_FRAC_BITS + 2;
  localparam int SHIFT = 30 - OUT_FRAC_BITS;

  logic        vld1_r, vld2_r, vld3_r, vld8_r;
  logic [31:0] f1_r;
  logic [31:0] u2_r;
  logic        neg2_r, neg3_r;
  logic [30:0] at3_r;
  logic signed [SW-1:0] sine8_r;

  logic signed [62:0] rad_prod;
  logic [31:0]        f_nxt;
  logic [63:0]        ph_prod;
  logic signed [32:0] t_nxt;
  logic [30:0]        at_nxt;

  spa_ctl_t    ctl3;
  spa_ctl_t    ctl7;
  logic [30:0] y7;
  logic [OUT_FRAC_BITS:0] mag;
  logic signed [SW-1:0]   sine_nxt;

  assign busy = 1'b0;

  // stage 1: turn fraction in Q0.32, floor wrap for negative angles
  always_comb begin
    rad_prod = 63'(in_angle) * 63'($signed({1'b0, INV_TWO_PI_Q32}));
    if (in_kind) begin
      f_nxt = rad_prod[47:16];
    end else begin
      f_nxt = {in_angle[15:0], 16'h0000};
    end
  end

  // stage 2: half turn folded out, phase scaled by 2*pi
  assign ph_prod = 64'(f1_r[30:0]) * 64'(TWO_PI_Q30);

  // stage 3: t = phase - pi/2, magnitude only
  always_comb begin
    t_nxt = $signed({1'b0, u2_r}) - $signed({2'b00, HALF_PI_Q30});
    if (t_nxt < 33'sd0) begin
      at_nxt = 31'(-t_nxt);
    end else begin
      at_nxt = t_nxt[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld8_r <= 1'b0;
    end else begin
      vld1_r <= start && !busy;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld8_r <= ctl7.vld;
    end
  end

  always_ff @(posedge clk) begin
    f1_r    <= f_nxt;
    u2_r    <= ph_prod[63:32];
    neg2_r  <= f1_r[31];
    neg3_r  <= neg2_r;
    at3_r   <= at_nxt;
    sine8_r <= sine_nxt;
  end

  assign ctl3.vld = vld3_r;
  assign ctl3.neg = neg3_r;

  spa_poly u_poly (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (ctl3),
    .at_in  (at3_r),
    .ctl_out(ctl7),
    .y_out  (y7)
  );

  // stage 8: round half up to the output step, then apply the sign
  generate
    if (SHIFT > 0) begin : g_rnd
      logic [30:0] rsum;
      assign rsum = y7 + (31'd1 << (SHIFT - 1));
      assign mag  = rsum[30:SHIFT];
    end else begin : g_exact
      assign mag = y7[OUT_FRAC_BITS:0];
    end
  endgenerate

  assign sine_nxt = ctl7.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  assign out_valid = vld8_r;
  assign out_sine  = sine8_r;

`ifndef SYNTHESIS
  localparam logic signed [SW-1:0] SINE_MAX = {2'b01, {OUT_FRAC_BITS{1'b0}}};
  localparam logic signed [SW-1:0] SINE_MIN = {2'b11, {OUT_FRAC_BITS{1'b0}}};

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(PIPE_DEPTH) out_valid)
    else $error("accepted item gave no result after pipeline latency");

  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n, PIPE_DEPTH) |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result strobe without an accepted item");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sine <= SINE_MAX) && (out_sine >= SINE_MIN))
    else $error("sine result outside [-1, +1]");
`endif

endmodule

// File: design/spa_poly.sv
module spa_poly
  import spa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  spa_ctl_t    ctl_in,
  input  logic [30:0] at_in,
  output spa_ctl_t    ctl_out,
  output logic [30:0] y_out
);

  spa_ctl_t    ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  logic [31:0] t2_4_r, t2_5_r, t2_6_r;
  logic [32:0] t4_5_r;
  logic [28:0] q_6_r;
  logic [30:0] y_7_r;

  logic [61:0] sq_nxt;
  logic [63:0] t4_full;
  logic [60:0] q_full;
  logic signed [34:0] y_sum;
  logic [30:0] y_nxt;

  always_comb begin
    sq_nxt  = 62'(at_in) * 62'(at_in);
    t4_full = 64'(t2_4_r) * 64'(t2_4_r);
    q_full  = 61'(t4_5_r) * 61'(QUARTIC_Q32);
    y_sum   = 35'(ONE_Q30) - 35'(t2_6_r >> 1) + 35'(q_6_r);
    // keep the magnitude inside [0, 1]
    if (y_sum < 35'sd0) begin
      y_nxt = '0;
    end else if (y_sum > 35'(ONE_Q30)) begin
      y_nxt = ONE_Q30;
    end else begin
      y_nxt = y_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
      ctl7_r <= '0;
    end else begin
      ctl4_r <= ctl_in;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
      ctl7_r <= ctl6_r;
    end
  end

  always_ff @(posedge clk) begin
    t2_4_r <= sq_nxt[61:30];
    t2_5_r <= t2_4_r;
    t4_5_r <= t4_full[62:30];
    t2_6_r <= t2_5_r;
    q_6_r  <= q_full[60:32];
    y_7_r  <= y_nxt;
  end

  assign ctl_out = ctl7_r;
  assign y_out   = y_7_r;

endmodule

// File: tb/sv/sine_poly_approx_chk.sv
package spa_tb_pkg;

  typedef enum logic {
    UNIT_TURNS   = 1'b0,
    UNIT_RADIANS = 1'b1
  } angle_unit_t;

endpackage

module sine_poly_approx_chk
  import spa_tb_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_kind,
  input  logic signed [31:0]             in_angle,
  input  logic                           out_valid,
  input  logic signed [OUT_FRAC_BITS+1:0] out_sine,
  output int                             errors,
  output int                             pending,
  output int                             checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] RAD_TO_TURN   = 64'sd683565276;
  localparam logic [63:0]        PHASE_SPAN    = 64'd6746518852;
  localparam logic signed [63:0] QUARTER_PHASE = 64'sd1686629713;
  localparam logic [63:0]        QUARTIC_COEF  = 64'd168796000;
  localparam logic signed [63:0] UNITY         = 64'sd1073741824;

  typedef struct {
    angle_unit_t                unit;
    logic [31:0]                angle;
    logic [OUT_FRAC_BITS+1:0]   sine;
  } sine_item_t;

  sine_item_t sine_queue[$];
  sine_item_t want;
  sine_item_t item;
  int         err_cnt = 0;
  int         ok_cnt  = 0;

  function automatic logic [OUT_FRAC_BITS+1:0] quartic_sine(angle_unit_t unit,
                                                            logic signed [31:0] angle);
    logic signed [63:0] scaled;
    logic [31:0]        frac;
    logic               negate;
    logic [63:0]        phase_raw;
    logic signed [63:0] t;
    logic [63:0]        at;
    logic [63:0]        t2;
    logic [63:0]        t4;
    logic [63:0]        q;
    logic signed [63:0] y;
    logic [63:0]        m;
    if (unit == UNIT_TURNS) begin
      frac = {angle[15:0], 16'h0000};
    end else begin
      // exact signed product in Q16.48, floor wrap falls out of the bit select
      scaled = 64'(angle) * RAD_TO_TURN;
      frac   = scaled[47:16];
    end
    negate    = frac[31];
    phase_raw = ({33'b0, frac[30:0]} * PHASE_SPAN) >> 32;
    t         = $signed(phase_raw) - QUARTER_PHASE;
    at        = (t < 0) ? 64'(-t) : 64'(t);
    t2        = (at * at) >> 30;
    t4        = (t2 * t2) >> 30;
    q         = (t4 * QUARTIC_COEF) >> 32;
    y         = UNITY - $signed(t2 >> 1) + $signed(q);
    if (y < 0) y = 0;
    if (y > UNITY) y = UNITY;
    m = 64'(y);
    // round half up to the output step
    if (OUT_FRAC_BITS < 30) m = (m + (64'd1 << (29 - OUT_FRAC_BITS))) >> (30 - OUT_FRAC_BITS);
    if (negate) m = -m;
    return m[OUT_FRAC_BITS+1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      // older item first, so a stray strobe is never matched to the one going in now
      if (out_valid) begin
        if (sine_queue.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, actual sine=%0d",
                   $time, $signed(out_sine));
        end else begin
          want = sine_queue.pop_front();
          if (out_sine !== want.sine) begin
            err_cnt++;
            $display("%0t: sine mismatch (unit=%s angle=%h): expected %0d, actual %0d",
                     $time, want.unit.name(), want.angle,
                     $signed(want.sine), $signed(out_sine));
          end
          ok_cnt++;
        end
      end
      if (start && !busy) begin
        item.unit  = angle_unit_t'(in_kind);
        item.angle = in_angle;
        item.sine  = quartic_sine(item.unit, in_angle);
        sine_queue.push_back(item);
      end
    end
    errors  <= err_cnt;
    pending <= sine_queue.size();
    checked <= ok_cnt;
  end

endmodule

// File: tb/sv/sine_poly_approx_tb.sv
module sine_poly_approx_tb
  import spa_tb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_FRAC_BITS  = 16;
  localparam int RANDOM_ITEMS   = 950;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int HALF_PI_RAD    = 102944;

  logic                           clk      = 1'b0;
  logic                           rst_n    = 1'b0;
  logic                           start    = 1'b0;
  logic                           in_kind  = 1'b0;
  logic signed [31:0]             in_angle = '0;
  logic                           busy;
  logic                           out_valid;
  logic signed [OUT_FRAC_BITS+1:0] out_sine;

  int errors;
  int pending;
  int checked;
  int idle_cycles = 0;
  int n_turns     = 0;
  int n_radians   = 0;

  logic [31:0] edge_angles [11] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_4000, 32'h0000_8000,
    32'h0000_C000, 32'hFFFF_C000, 32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_FFFF,
    32'h0000_0001
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sine_poly_approx #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_kind  (in_kind),
    .in_angle (in_angle),
    .out_valid(out_valid),
    .out_sine (out_sine)
  );

  sine_poly_approx_chk #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_kind  (in_kind),
    .in_angle (in_angle),
    .out_valid(out_valid),
    .out_sine (out_sine),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("** sine_poly_approx: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_angle(angle_unit_t unit, logic [31:0] angle, bit may_idle);
    int gap;
    gap = may_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= unit;
    in_angle <= angle;
    do @(posedge clk); while (busy);
    if (unit == UNIT_TURNS) n_turns++;
    else n_radians++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int          mode;
    int          k;
    logic [31:0] a;
    angle_unit_t unit;
    bit          may_idle;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (edge_angles[j]) begin
      send_angle(UNIT_TURNS, edge_angles[j], 1'b1);
      send_angle(UNIT_RADIANS, edge_angles[j], 1'b1);
    end
    send_angle(UNIT_RADIANS, HALF_PI_RAD, 1'b0);
    send_angle(UNIT_RADIANS, 2 * HALF_PI_RAD, 1'b0);
    send_angle(UNIT_RADIANS, -HALF_PI_RAD, 1'b0);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      unit = angle_unit_t'($urandom_range(0, 1));
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        a = $urandom();
      end else if (mode < 6) begin
        a = $urandom_range(0, 1 << 18);
        if ($urandom_range(0, 1)) a = -a;
      end else if (mode < 8) begin
        // near quarter-turn boundaries, where the half-turn test or the sign of t flips
        unit = UNIT_TURNS;
        a = ($urandom() & 32'hFFFF_C000) + $urandom_range(0, 6) - 3;
      end else begin
        unit = UNIT_RADIANS;
        k = $urandom_range(0, 40) - 20;
        a = k * HALF_PI_RAD + $urandom_range(0, 64) - 32;
      end
      // every fourth stretch of 64 items runs back to back
      may_idle = ((i / 64) % 4) != 1;
      send_angle(unit, a, may_idle);
      if (i == RANDOM_ITEMS / 2) drain_results();
    end

    drain_results();
    repeat (spa_pkg::PIPE_DEPTH + 4) @(posedge clk);

    $display("angles sent: %0d in turns, %0d in radians (edges, quadrant borders, wide random)",
             n_turns, n_radians);
    $display("results compared: %0d, mismatches: %0d", checked, errors);
    if (errors == 0) begin
      $display("** sine_poly_approx: PASSED **");
    end else begin
      $display("** sine_poly_approx: FAILED **");
    end
    $finish;
  end

endmodule
